[hdl/ehc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ehc_pkg
// Shared types and constants for the ELF64 image header checker.
// ----------------------------------------------------------------------------
package ehc_pkg;

    localparam int ADDR_W  = 64;
    localparam int COUNT_W = 16;

    // Fixed header values
    localparam logic [7:0]  MAG0        = 8'h7F;
    localparam logic [7:0]  MAG1        = 8'h45;   // 'E'
    localparam logic [7:0]  MAG2        = 8'h4C;   // 'L'
    localparam logic [7:0]  MAG3        = 8'h46;   // 'F'
    localparam logic [7:0]  CLASS_64    = 8'd2;
    localparam logic [7:0]  DATA_LE     = 8'd1;
    localparam logic [15:0] TYPE_EXEC   = 16'd2;
    localparam logic [15:0] MACH_X86_64 = 16'h003E;
    localparam logic [15:0] HDR_BYTES   = 16'd64;
    localparam logic [15:0] REC_BYTES   = 16'd56;
    localparam logic [31:0] VERSION_1   = 32'd1;
    localparam logic [31:0] KIND_LOAD   = 32'd1;

    // Item kinds on the func field
    localparam logic FUNC_HEADER = 1'b0;
    localparam logic FUNC_RECORD = 1'b1;

    typedef enum logic [2:0] {
        FAIL_OK         = 3'd0,
        FAIL_HEADER     = 3'd1,
        FAIL_FILE_MEM   = 3'd2,
        FAIL_BEYOND     = 3'd3,
        FAIL_EMPTY      = 3'd4,
        FAIL_NONE       = 3'd5,
        FAIL_ENTRY      = 3'd6,
        FAIL_UNEXPECTED = 3'd7
    } fail_t;

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_RECORDS = 2'd1
    } phase_t;

    typedef struct packed {
        logic              func;
        logic [47:0]       ident_bytes;
        logic [63:0]       header_shorts;
        logic [31:0]       version_or_kind;
        logic [COUNT_W-1:0] table_count;
        logic [ADDR_W-1:0] address;
        logic [ADDR_W-1:0] file_offset;
        logic [ADDR_W-1:0] file_bytes;
        logic [ADDR_W-1:0] memory_bytes;
    } item_t;

    typedef struct packed {
        logic               done_res;
        logic               image_valid;
        logic [2:0]         fail_code;
        logic [COUNT_W-1:0] seg_count;
        logic [ADDR_W-1:0]  low_addr;
        logic [ADDR_W-1:0]  high_addr;
        logic [ADDR_W-1:0]  entry_addr;
    } result_t;

endpackage

[hdl/ehc_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ehc_if
// Valid/ready channels carrying header items in and check results out.
// ----------------------------------------------------------------------------
interface ehc_item_if;
    import ehc_pkg::*;

    logic               valid;
    logic               ready;
    logic               func;
    logic [47:0]        ident_bytes;
    logic [63:0]        header_shorts;
    logic [31:0]        version_or_kind;
    logic [COUNT_W-1:0] table_count;
    logic [ADDR_W-1:0]  address;
    logic [ADDR_W-1:0]  file_offset;
    logic [ADDR_W-1:0]  file_bytes;
    logic [ADDR_W-1:0]  memory_bytes;

    modport source (
        output valid, func, ident_bytes, header_shorts, version_or_kind,
               table_count, address, file_offset, file_bytes, memory_bytes,
        input  ready
    );
    modport sink (
        input  valid, func, ident_bytes, header_shorts, version_or_kind,
               table_count, address, file_offset, file_bytes, memory_bytes,
        output ready
    );
endinterface

interface ehc_result_if;
    import ehc_pkg::*;

    logic               valid;
    logic               ready;
    logic               done_res;
    logic               image_valid;
    logic [2:0]         fail_code;
    logic [COUNT_W-1:0] seg_count;
    logic [ADDR_W-1:0]  low_addr;
    logic [ADDR_W-1:0]  high_addr;
    logic [ADDR_W-1:0]  entry_addr;

    modport source (
        output valid, done_res, image_valid, fail_code, seg_count,
               low_addr, high_addr, entry_addr,
        input  ready
    );
    modport sink (
        input  valid, done_res, image_valid, fail_code, seg_count,
               low_addr, high_addr, entry_addr,
        output ready
    );
endinterface

[hdl/ehc_in_stage.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ehc_in_stage
// Input register: captures one word per cycle while it is empty or the held word moves on, and holds it until checked.
// ----------------------------------------------------------------------------
module ehc_in_stage (
    input  logic           clk,
    input  logic           rst_n,
    ehc_item_if.sink       item,
    input  logic           advance,
    output logic           held_valid,
    output ehc_pkg::item_t held_item
);
    import ehc_pkg::*;

    logic  valid_reg;
    item_t data_reg;
    logic  accept;

    // Take a new word when empty or when the held word moves on
    assign item.ready = !valid_reg || advance;
    assign accept     = item.valid && item.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            valid_reg <= 1'b0;
        end
    end

    // Capture the payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            data_reg.func            <= item.func;
            data_reg.ident_bytes     <= item.ident_bytes;
            data_reg.header_shorts   <= item.header_shorts;
            data_reg.version_or_kind <= item.version_or_kind;
            data_reg.table_count     <= item.table_count;
            data_reg.address         <= item.address;
            data_reg.file_offset     <= item.file_offset;
            data_reg.file_bytes      <= item.file_bytes;
            data_reg.memory_bytes    <= item.memory_bytes;
        end
    end

    assign held_valid = valid_reg;
    assign held_item  = data_reg;

endmodule

[hdl/ehc_check.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ehc_check
// Header and segment checks, running image state and result formation.
// ----------------------------------------------------------------------------
module ehc_check (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_write,
    input  logic [63:0]      cfg_data,
    input  logic             fire,
    input  ehc_pkg::item_t   cur,
    output ehc_pkg::result_t result
);
    import ehc_pkg::*;

    phase_t              phase_reg, phase_next;
    logic [COUNT_W-1:0]  left_reg, left_next;
    logic [ADDR_W-1:0]   entry_reg, entry_next;
    logic [ADDR_W-1:0]   low_reg, low_next;
    logic [ADDR_W-1:0]   high_reg, high_next;
    logic [COUNT_W-1:0]  count_reg, count_next;
    logic [ADDR_W-1:0]   img_bytes_reg;

    logic                is_header;
    logic                hdr_ok;
    logic [21:0]         tbl_bytes;
    logic [ADDR_W-1:0]   table_end;
    logic                unexpected;
    logic                is_load;
    logic [ADDR_W-1:0]   seg_end;
    logic [ADDR_W-1:0]   data_end;
    fail_t               seg_code;
    logic                seg_fail;
    logic                take_low;
    logic                take_high;
    logic [COUNT_W-1:0]  left_dec;
    logic [COUNT_W-1:0]  count_inc;
    logic                last_rec;
    logic                entry_below;
    logic                entry_above;

    // Header checks
    assign is_header = (cur.func == FUNC_HEADER);
    assign tbl_bytes = 22'(cur.table_count) * 22'(REC_BYTES);
    assign table_end = cur.file_offset + 64'(tbl_bytes);
    assign hdr_ok    = (img_bytes_reg >= 64'(HDR_BYTES))
                    && (cur.ident_bytes[7:0]   == MAG0)
                    && (cur.ident_bytes[15:8]  == MAG1)
                    && (cur.ident_bytes[23:16] == MAG2)
                    && (cur.ident_bytes[31:24] == MAG3)
                    && (cur.ident_bytes[39:32] == CLASS_64)
                    && (cur.ident_bytes[47:40] == DATA_LE)
                    && (cur.header_shorts[15:0]  == TYPE_EXEC)
                    && (cur.header_shorts[31:16] == MACH_X86_64)
                    && (cur.header_shorts[47:32] == HDR_BYTES)
                    && (cur.header_shorts[63:48] == REC_BYTES)
                    && (cur.version_or_kind == VERSION_1)
                    && (cur.table_count != '0)
                    && (table_end <= img_bytes_reg);

    // Segment checks
    assign unexpected = (phase_reg != PH_RECORDS) || (left_reg == '0);
    assign is_load    = (cur.version_or_kind == KIND_LOAD);
    assign seg_end    = cur.address + cur.memory_bytes;
    assign data_end   = cur.file_offset + cur.file_bytes;

    always_comb
    begin
        if (cur.file_bytes > cur.memory_bytes)
        begin
            seg_code = FAIL_FILE_MEM;
        end
        else if (data_end > img_bytes_reg)
        begin
            seg_code = FAIL_BEYOND;
        end
        else if (seg_end <= cur.address)
        begin
            seg_code = FAIL_EMPTY;
        end
        else
        begin
            seg_code = FAIL_OK;
        end
    end

    assign seg_fail  = is_load && (seg_code != FAIL_OK);
    assign take_low  = is_load && ((count_reg == '0) || (cur.address < low_reg));
    assign take_high = is_load && (seg_end > high_reg);
    assign count_inc = is_load ? count_reg + COUNT_W'(1) : count_reg;
    assign left_dec  = left_reg - COUNT_W'(1);
    assign last_rec  = (left_dec == '0);

    // Entry against the updated span, compared in parallel with the update
    assign entry_below = take_low  ? (entry_reg < cur.address) : (entry_reg < low_reg);
    assign entry_above = take_high ? (entry_reg >= seg_end)    : (entry_reg >= high_reg);

    // Next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (fire)
        begin
            if (is_header)
            begin
                phase_next = hdr_ok ? PH_RECORDS : PH_IDLE;
            end
            else if (unexpected || seg_fail || last_rec)
            begin
                phase_next = PH_IDLE;
            end
        end
    end

    // Image state and result
    always_comb
    begin
        left_next  = left_reg;
        entry_next = entry_reg;
        low_next   = low_reg;
        high_next  = high_reg;
        count_next = count_reg;

        result.done_res    = 1'b0;
        result.image_valid = 1'b0;
        result.fail_code   = FAIL_OK;
        result.seg_count   = count_reg;
        result.low_addr    = low_reg;
        result.high_addr   = high_reg;
        result.entry_addr  = entry_reg;

        if (is_header)
        begin
            // Start a new image; drop anything in progress
            low_next   = '0;
            high_next  = '0;
            count_next = '0;
            result.seg_count = '0;
            result.low_addr  = '0;
            result.high_addr = '0;
            if (hdr_ok)
            begin
                entry_next = cur.address;
                left_next  = cur.table_count;
                result.entry_addr = cur.address;
            end
            else
            begin
                entry_next = '0;
                left_next  = '0;
                result.done_res   = 1'b1;
                result.fail_code  = FAIL_HEADER;
                result.entry_addr = '0;
            end
        end
        else if (unexpected)
        begin
            result.done_res  = 1'b1;
            result.fail_code = FAIL_UNEXPECTED;
        end
        else if (seg_fail)
        begin
            left_next        = '0;
            result.done_res  = 1'b1;
            result.fail_code = seg_code;
        end
        else
        begin
            if (take_low)
            begin
                low_next = cur.address;
            end
            if (take_high)
            begin
                high_next = seg_end;
            end
            count_next = count_inc;
            left_next  = left_dec;
            result.seg_count = count_inc;
            result.low_addr  = take_low  ? cur.address : low_reg;
            result.high_addr = take_high ? seg_end     : high_reg;
            if (last_rec)
            begin
                result.done_res = 1'b1;
                if (count_inc == '0)
                begin
                    result.fail_code = FAIL_NONE;
                end
                else if (entry_below || entry_above)
                begin
                    result.fail_code = FAIL_ENTRY;
                end
                else
                begin
                    result.image_valid = 1'b1;
                end
            end
        end
    end

    // Advance state on each checked word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            left_reg  <= '0;
            entry_reg <= '0;
            low_reg   <= '0;
            high_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            if (fire)
            begin
                left_reg  <= left_next;
                entry_reg <= entry_next;
                low_reg   <= low_next;
                high_reg  <= high_next;
                count_reg <= count_next;
            end
        end
    end

    // Image size register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            img_bytes_reg <= '0;
        end
        else if (cfg_write)
        begin
            img_bytes_reg <= cfg_data;
        end
    end

endmodule

[hdl/ehc_out_stage.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ehc_out_stage
// Result register: holds one result word until the sink takes it.
// ----------------------------------------------------------------------------
module ehc_out_stage (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  ehc_pkg::result_t result,
    output logic             can_load,
    ehc_result_if.source     res
);
    import ehc_pkg::*;

    logic    valid_reg;
    result_t data_reg;

    // Accept a new result when empty or when the held one leaves now
    assign can_load = !valid_reg || res.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (res.ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= result;
        end
    end

    // Drive the result channel
    assign res.valid       = valid_reg;
    assign res.done_res    = data_reg.done_res;
    assign res.image_valid = data_reg.image_valid;
    assign res.fail_code   = data_reg.fail_code;
    assign res.seg_count   = data_reg.seg_count;
    assign res.low_addr    = data_reg.low_addr;
    assign res.high_addr   = data_reg.high_addr;
    assign res.entry_addr  = data_reg.entry_addr;

endmodule

[hdl/elf64_image_header_checker.sv]
`timescale 1ns / 1ps
// A word in the input register is checked combinationally and loaded into the result
//   register when that register has room; the sink takes it from there.
// Throughput: one word per cycle while the result channel takes results; the input
//   register and the result register each hold one word; checking is combinational.
// Reset: rst_n empties both stages and clears the image state and the image size to zero.
// A stalled result channel holds the pipe; at most two words are in flight.
// ----------------------------------------------------------------------------
// elf64_image_header_checker
// Top level: ELF64 file header and program header record validation.
// ----------------------------------------------------------------------------
module elf64_image_header_checker (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_write,
    input  logic [63:0]  cfg_data,
    ehc_item_if.sink     item,
    ehc_result_if.source res
);
    import ehc_pkg::*;

    logic    held_valid;
    item_t   held_item;
    result_t result;
    logic    can_load;
    logic    fire;

    // Check the held word when the result register has room
    assign fire = held_valid && can_load;

    ehc_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item),
        .advance    (fire),
        .held_valid (held_valid),
        .held_item  (held_item)
    );

    ehc_check u_check (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_data  (cfg_data),
        .fire      (fire),
        .cur       (held_item),
        .result    (result)
    );

    ehc_out_stage u_out_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (fire),
        .result   (result),
        .can_load (can_load),
        .res      (res)
    );

endmodule
